>>> hw/rtl/tsms_pkg.sv
// ----------------------------------------------------------------------------
// tsms_pkg
// Types, codes and timing constants shared by the timed search motion
// sequencer.
// ----------------------------------------------------------------------------
package tsms_pkg;

    // input transaction kinds
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_MARKER   = 2'd1;
    localparam logic [1:0] KIND_OBSTACLE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SPIN_FIRST    = 2'd0;
    localparam logic [1:0] CFG_FORWARD_TICKS = 2'd1;
    localparam logic [1:0] CFG_SKEW_MODE     = 2'd2;

    // internal pattern phase codes
    localparam logic [1:0] PH_FWD = 2'd0;
    localparam logic [1:0] PH_A   = 2'd1;
    localparam logic [1:0] PH_B   = 2'd2;
    localparam logic [1:0] PH_C   = 2'd3;

    // reported phase codes
    localparam logic [2:0] OUT_SPIN = 3'd0;
    localparam logic [2:0] OUT_FWD  = 3'd1;
    localparam logic [2:0] OUT_A    = 3'd2;
    localparam logic [2:0] OUT_B    = 3'd3;
    localparam logic [2:0] OUT_C    = 3'd4;

    // skew codes
    localparam logic [1:0] SKEW_RIGHT = 2'b01;
    localparam logic [1:0] SKEW_LEFT  = 2'b11;

    // durations in 50 ms ticks, velocities in thousandths
    localparam logic [31:0] SPIN_TICKS       = 32'd130;
    localparam logic [31:0] TURN_A_TICKS     = 32'd70;
    localparam logic [31:0] TURN_B_TICKS     = 32'd140;
    localparam logic [31:0] TURN_C_TICKS     = 32'd70;
    localparam logic [4:0]  SKEW_EXTRA_TICKS = 5'd20;
    localparam logic [2:0]  CLEAR_RUN_LEN    = 3'd6;
    localparam logic [10:0] LIN_MILLI        = 11'd650;
    localparam logic signed [11:0] ANG_MILLI = 12'sd1000;
    localparam logic [15:0] FORWARD_RESET    = 16'd80;
    localparam logic [7:0]  LEGS_MAX         = 8'd255;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [7:0] msg_value;
    } t_in;

    typedef struct packed {
        logic [10:0]        linear_milli;
        logic signed [11:0] angular_milli;
        logic [2:0]         phase;
        logic [7:0]         cycle_count;
    } t_out;

    typedef struct packed {
        logic        spin_first;
        logic [15:0] forward_ticks;
        logic [1:0]  skew_mode;
    } t_cfg;

    typedef struct packed {
        logic marker_seen;
        logic obstacle_flag;
    } t_flags;

    typedef struct packed {
        logic [31:0] tick_time;
        logic [31:0] deadline;
        logic [1:0]  pattern_phase;
        logic [1:0]  saved_phase;
        logic        timing_started;
        logic        spin_finished;
        logic [7:0]  legs_done;
        logic        pausing;
    } t_state;

endpackage

>>> hw/rtl/tsms_event.sv
// ----------------------------------------------------------------------------
// tsms_event
// Marker and obstacle message filter; obstacle clears after a run of six
// zero messages.
// ----------------------------------------------------------------------------
module tsms_event (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  tsms_pkg::t_in    i_item,
    output tsms_pkg::t_flags o_flags
);

    logic       r_marker;
    logic       r_obstacle;
    logic [2:0] r_clear_run;
    logic       n_marker;
    logic       n_obstacle;
    logic [2:0] n_clear_run;
    logic [2:0] w_run_inc;

    assign w_run_inc = r_clear_run + 3'd1;

    always_comb begin
        n_marker    = r_marker;
        n_obstacle  = r_obstacle;
        n_clear_run = r_clear_run;
        if (i_item.kind == tsms_pkg::KIND_MARKER) begin
            n_marker = (i_item.msg_value == 8'sd1);
        end else if (i_item.kind == tsms_pkg::KIND_OBSTACLE) begin
            if (i_item.msg_value != 8'sd0) begin
                n_obstacle  = 1'b1;
                n_clear_run = 3'd0;
            end else if (r_obstacle) begin
                if (w_run_inc >= tsms_pkg::CLEAR_RUN_LEN) begin
                    n_obstacle  = 1'b0;
                    n_clear_run = 3'd0;
                end else begin
                    n_clear_run = w_run_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker    <= 1'b0;
            r_obstacle  <= 1'b0;
            r_clear_run <= 3'd0;
        end else if (i_take) begin
            r_marker    <= n_marker;
            r_obstacle  <= n_obstacle;
            r_clear_run <= n_clear_run;
        end
    end

    assign o_flags.marker_seen   = r_marker;
    assign o_flags.obstacle_flag = r_obstacle;

endmodule

>>> hw/rtl/tsms_pattern.sv
// ----------------------------------------------------------------------------
// tsms_pattern
// Tick logic: pause and resume, spin phase, search pattern phases,
// deadlines and the velocity command.
// ----------------------------------------------------------------------------
module tsms_pattern (
    input  tsms_pkg::t_state i_state,
    input  tsms_pkg::t_cfg   i_cfg,
    input  tsms_pkg::t_flags i_flags,
    output tsms_pkg::t_state o_state,
    output logic             o_emit,
    output tsms_pkg::t_out   o_cmd
);

    logic [31:0]        w_tick;
    logic [31:0]        w_diff;
    logic               w_reached;
    logic               w_right;
    logic               w_skewed;
    logic signed [11:0] w_side;
    logic [12:0]        w_extra;
    logic [1:0]         w_phase;
    logic               w_started;
    logic [31:0]        w_fwd_dl;

    assign w_tick    = i_state.tick_time + 32'd1;
    assign w_diff    = w_tick - i_state.deadline;
    assign w_reached = !w_diff[31];
    assign w_right   = (i_cfg.skew_mode == tsms_pkg::SKEW_RIGHT);
    assign w_skewed  = w_right || (i_cfg.skew_mode == tsms_pkg::SKEW_LEFT);
    assign w_side    = w_right ? -tsms_pkg::ANG_MILLI : tsms_pkg::ANG_MILLI;
    assign w_extra   = w_skewed ? (13'(i_state.legs_done) * 13'(tsms_pkg::SKEW_EXTRA_TICKS))
                                : 13'd0;
    assign w_fwd_dl  = w_tick + {16'd0, i_cfg.forward_ticks};
    // a resume restores the saved phase and restarts forward timing
    assign w_phase   = i_state.pausing ? i_state.saved_phase : i_state.pattern_phase;
    assign w_started = i_state.pausing ? 1'b0 : i_state.timing_started;

    always_comb begin
        o_state           = i_state;
        o_state.tick_time = w_tick;
        o_emit            = 1'b0;
        o_cmd             = '0;
        if (i_flags.marker_seen) begin
            o_emit = 1'b0;
        end else if (i_flags.obstacle_flag) begin
            if (!i_state.pausing) begin
                o_state.pausing     = 1'b1;
                o_state.saved_phase = i_state.pattern_phase;
            end
        end else begin
            o_emit                 = 1'b1;
            o_state.pausing        = 1'b0;
            o_state.pattern_phase  = w_phase;
            o_state.timing_started = w_started;
            if (i_cfg.spin_first && !i_state.spin_finished) begin
                o_cmd.angular_milli = tsms_pkg::ANG_MILLI;
                o_cmd.phase         = tsms_pkg::OUT_SPIN;
                if (w_reached) begin
                    o_state.spin_finished  = 1'b1;
                    o_state.timing_started = 1'b0;
                end
            end else if (!w_started) begin
                o_state.pattern_phase  = tsms_pkg::PH_FWD;
                o_state.deadline       = w_fwd_dl;
                o_state.timing_started = 1'b1;
                o_cmd.linear_milli     = tsms_pkg::LIN_MILLI;
                o_cmd.phase            = tsms_pkg::OUT_FWD;
            end else begin
                unique case (w_phase)
                    tsms_pkg::PH_A: begin
                        o_cmd.angular_milli = w_side;
                        o_cmd.phase         = tsms_pkg::OUT_A;
                        if (w_reached) begin
                            o_state.pattern_phase = tsms_pkg::PH_B;
                            o_state.deadline      = w_tick + tsms_pkg::TURN_B_TICKS;
                        end
                    end
                    tsms_pkg::PH_B: begin
                        o_cmd.angular_milli = -w_side;
                        o_cmd.phase         = tsms_pkg::OUT_B;
                        if (w_reached) begin
                            o_state.pattern_phase = tsms_pkg::PH_C;
                            o_state.deadline      = w_tick + tsms_pkg::TURN_C_TICKS
                                                  + {19'd0, w_extra};
                        end
                    end
                    tsms_pkg::PH_C: begin
                        o_cmd.angular_milli = w_side;
                        o_cmd.phase         = tsms_pkg::OUT_C;
                        if (w_reached) begin
                            o_state.pattern_phase = tsms_pkg::PH_FWD;
                            o_state.deadline      = w_fwd_dl;
                        end
                    end
                    default: begin
                        o_cmd.linear_milli = tsms_pkg::LIN_MILLI;
                        o_cmd.phase        = tsms_pkg::OUT_FWD;
                        if (w_reached) begin
                            if (i_state.legs_done < tsms_pkg::LEGS_MAX) begin
                                o_state.legs_done = i_state.legs_done + 8'd1;
                            end
                            o_state.pattern_phase = tsms_pkg::PH_A;
                            o_state.deadline      = w_tick + tsms_pkg::TURN_A_TICKS;
                        end
                    end
                endcase
            end
        end
        o_cmd.cycle_count = o_state.legs_done;
    end

endmodule

>>> hw/rtl/timed_search_motion_sequencer_core.sv
// ----------------------------------------------------------------------------
// timed_search_motion_sequencer_core
// Search pattern sequencer: spin, forward, three turns, driven by 50 ms
// ticks and paused by marker and obstacle messages.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | sink      | i_in_valid/o_in_stall | t_in  (kind, msg_value)
//  out      | source    | o_out_valid/i_out_stall| t_out (lin, ang, phase, count)
//  cfg      | sink      | i_cfg_we             | index + 16-bit write data
//
// Each transaction is captured in an input register, processed by
// combinational logic and, for an emitting tick, written to the result
// register: one transaction per cycle while the result is not stalled.
// The input register drains whenever the result register is empty or being
// taken, so a stalled result holds one further transaction at most.
// Synchronous active-low reset clears all sequencing state and both valids;
// configuration returns to spin_first 0, forward_ticks 80, skew_mode 0.
// Marker and obstacle transactions update filter state without result.
// ----------------------------------------------------------------------------
module timed_search_motion_sequencer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tsms_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tsms_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_wdata
);

    tsms_pkg::t_cfg   r_cfg;
    logic             r_in_valid;
    tsms_pkg::t_in    r_in_data;
    logic             r_out_valid;
    tsms_pkg::t_out   r_out_data;
    tsms_pkg::t_state r_state;
    tsms_pkg::t_state n_state;
    tsms_pkg::t_flags w_flags;
    tsms_pkg::t_out   w_cmd;
    logic             w_emit;
    logic             w_advance;
    logic             w_is_tick;

    // advance the held transaction when the result slot is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_is_tick  = (r_in_data.kind == tsms_pkg::KIND_TICK);
    assign o_in_stall = r_in_valid && !w_advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spin_first    <= 1'b0;
            r_cfg.forward_ticks <= tsms_pkg::FORWARD_RESET;
            r_cfg.skew_mode     <= 2'b00;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsms_pkg::CFG_SPIN_FIRST:    r_cfg.spin_first    <= i_cfg_wdata[0];
                tsms_pkg::CFG_FORWARD_TICKS: r_cfg.forward_ticks <= i_cfg_wdata;
                tsms_pkg::CFG_SKEW_MODE:     r_cfg.skew_mode     <= i_cfg_wdata[1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // message filter updates on marker and obstacle transactions
    tsms_event u_event (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_advance),
        .i_item  (r_in_data),
        .o_flags (w_flags)
    );

    tsms_pattern u_pattern (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_flags (w_flags),
        .o_state (n_state),
        .o_emit  (w_emit),
        .o_cmd   (w_cmd)
    );

    // sequencing state moves only on ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tick_time      <= 32'd0;
            r_state.deadline       <= tsms_pkg::SPIN_TICKS;
            r_state.pattern_phase  <= tsms_pkg::PH_FWD;
            r_state.saved_phase    <= tsms_pkg::PH_FWD;
            r_state.timing_started <= 1'b0;
            r_state.spin_finished  <= 1'b0;
            r_state.legs_done      <= 8'd0;
            r_state.pausing        <= 1'b0;
        end else if (w_advance && w_is_tick) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_is_tick && w_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= w_cmd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sim/timed_search_motion_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_search_motion_sequencer_core_tb
// Self-checking bench for the search motion sequencer. A driver feeds tick,
// marker and obstacle transactions from a queue, and a monitor runs every
// accepted transaction through a cycle-free model of the sequencer. It then
// compares each velocity command that leaves the block, field by field,
// against the oldest predicted one. Settings are changed only while the
// block is idle. The run sweeps spin on/off, the forward leg extremes and
// every skew code.
// ----------------------------------------------------------------------------
module timed_search_motion_sequencer_core_tb;
    import tsms_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;   // cycles without any transaction
    localparam int         DRAIN_CYCLES   = 4;      // input and result registers plus margin
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam logic [1:0] SKEW_NONE      = 2'b00;
    localparam logic [1:0] SKEW_ODD       = 2'b10;  // the -2 code, treated as no skew

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_SPIN_FIRST;
    logic [15:0] i_cfg_wdata = '0;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_in  pending_items[$];   // transactions waiting for the driver
    t_out expected_cmds[$];   // predicted commands, oldest first
    t_out want;
    t_out fresh_cmd;
    logic in_taken = 1'b0;    // driver's item went in at the last rising edge
    logic moved;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   idle_cycles   = 0;
    int   errors        = 0;
    int   queued        = 0;
    int   cmds_checked  = 0;
    int   n_tick        = 0;
    int   n_marker      = 0;
    int   n_obstacle    = 0;
    int   n_unused      = 0;
    int   peak_legs     = 0;

    // Settings as the model sees them; they start at the reset values.
    logic        cfg_spin = 1'b0;
    logic [15:0] cfg_fwd  = FORWARD_RESET;
    logic [1:0]  cfg_skew = SKEW_NONE;

    // Sequencer state of the model.
    logic [31:0] seq_ticks    = '0;
    logic [31:0] seq_deadline = SPIN_TICKS;
    logic [1:0]  seq_phase    = PH_FWD;
    logic [1:0]  seq_saved    = PH_FWD;
    logic        seq_timing   = 1'b0;
    logic        seq_spun     = 1'b0;
    logic        seq_marker   = 1'b0;
    logic        seq_obstacle = 1'b0;
    logic        seq_pausing  = 1'b0;
    logic [2:0]  seq_clear    = '0;
    logic [7:0]  seq_legs     = '0;

    timed_search_motion_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic t_out motion_cmd(input logic [10:0] lin,
                                        input logic signed [11:0] ang,
                                        input logic [2:0] ph);
        t_out c;
        c.linear_milli  = lin;
        c.angular_milli = ang;
        c.phase         = ph;
        c.cycle_count   = seq_legs;
        return c;
    endfunction

    // Advance the model by one transaction; return 1 with the command when
    // the transaction is a tick that emits one.
    function automatic bit next_motion_cmd(input t_in item, output t_out cmd);
        logic signed [11:0] side;
        logic               skewed;
        logic [31:0]        lag;
        cmd    = '0;
        side   = (cfg_skew == SKEW_RIGHT) ? -ANG_MILLI : ANG_MILLI;
        skewed = (cfg_skew == SKEW_RIGHT) || (cfg_skew == SKEW_LEFT);

        if (item.kind == KIND_MARKER) begin
            seq_marker = (item.msg_value == 8'sd1);
            return 1'b0;
        end
        if (item.kind == KIND_OBSTACLE) begin
            if (item.msg_value != 8'sd0) begin
                seq_obstacle = 1'b1;
                seq_clear    = '0;
            end else if (seq_obstacle) begin
                seq_clear = seq_clear + 3'd1;
                if (seq_clear >= CLEAR_RUN_LEN) begin
                    seq_obstacle = 1'b0;
                    seq_clear    = '0;
                end
            end
            return 1'b0;
        end
        if (item.kind != KIND_TICK) return 1'b0;

        // time runs even while the block is silent
        seq_ticks = seq_ticks + 32'd1;
        if (seq_marker) return 1'b0;
        if (seq_obstacle) begin
            if (!seq_pausing) begin
                seq_pausing = 1'b1;
                seq_saved   = seq_phase;
            end
            return 1'b0;
        end
        if (seq_pausing) begin
            seq_pausing = 1'b0;
            seq_phase   = seq_saved;
            seq_timing  = 1'b0;
        end

        // deadline reached when the wrapped difference is not negative
        lag = seq_ticks - seq_deadline;

        if (cfg_spin && !seq_spun) begin
            cmd = motion_cmd(11'd0, ANG_MILLI, OUT_SPIN);
            if (!lag[31]) begin
                seq_spun   = 1'b1;
                seq_timing = 1'b0;
            end
            return 1'b1;
        end

        if (!seq_timing) begin
            seq_phase    = PH_FWD;
            seq_deadline = seq_ticks + 32'(cfg_fwd);
            seq_timing   = 1'b1;
            cmd = motion_cmd(LIN_MILLI, 12'sd0, OUT_FWD);
            return 1'b1;
        end

        case (seq_phase)
            PH_A: begin
                cmd = motion_cmd(11'd0, side, OUT_A);
                if (!lag[31]) begin
                    seq_phase    = PH_B;
                    seq_deadline = seq_ticks + TURN_B_TICKS;
                end
            end
            PH_B: begin
                cmd = motion_cmd(11'd0, -side, OUT_B);
                if (!lag[31]) begin
                    seq_phase    = PH_C;
                    seq_deadline = seq_ticks + TURN_C_TICKS
                                 + (skewed ? 32'(SKEW_EXTRA_TICKS) * 32'(seq_legs) : 32'd0);
                end
            end
            PH_C: begin
                cmd = motion_cmd(11'd0, side, OUT_C);
                if (!lag[31]) begin
                    seq_phase    = PH_FWD;
                    seq_deadline = seq_ticks + 32'(cfg_fwd);
                end
            end
            default: begin
                // the leg count moves before the command reports it
                if (!lag[31]) begin
                    if (seq_legs < LEGS_MAX) seq_legs = seq_legs + 8'd1;
                    seq_phase    = PH_A;
                    seq_deadline = seq_ticks + TURN_A_TICKS;
                end
                cmd = motion_cmd(LIN_MILLI, 12'sd0, OUT_FWD);
            end
        endcase
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Hold a stalled item as it
    // is, and advance to the next one only once the last was taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_data  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Check the result
    // first, so a command leaving in the same cycle as a new tick is matched
    // against the older expectation. Then run the new transaction through
    // the model.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;

            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                cmds_checked++;
                if (o_out_data.cycle_count > peak_legs) peak_legs = o_out_data.cycle_count;
                if (expected_cmds.size() == 0) begin
                    errors++;
                    $display("%0t ns: command with none expected: expected none, %s",
                             $time, "actual");
                    $display("    %0d %0d %0d %0d",
                             o_out_data.linear_milli, o_out_data.angular_milli,
                             o_out_data.phase, o_out_data.cycle_count);
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("linear_milli", want.linear_milli, o_out_data.linear_milli);
                    check_field("angular_milli", int'(want.angular_milli),
                                int'(o_out_data.angular_milli));
                    check_field("phase", want.phase, o_out_data.phase);
                    check_field("cycle_count", want.cycle_count, o_out_data.cycle_count);
                end
            end

            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                case (i_in_data.kind)
                    KIND_TICK:     n_tick++;
                    KIND_MARKER:   n_marker++;
                    KIND_OBSTACLE: n_obstacle++;
                    default:       n_unused++;
                endcase
                if (next_motion_cmd(i_in_data, fresh_cmd)) expected_cmds.push_back(fresh_cmd);
            end

            in_taken <= i_in_valid && !o_in_stall;

            // drop the run if nothing moves for too long
            if (moved) idle_cycles = 0;
            else       idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: watchdog: no transaction in %0d cycles,",
                         $time, idle_cycles);
                $display("    %0d commands outstanding", expected_cmds.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [1:0] kind, input logic [7:0] value);
        t_in item;
        item.kind      = kind;
        item.msg_value = value;
        pending_items.push_back(item);
        if (kind != KIND_UNUSED) queued++;
    endtask

    // Wait until the driver is empty and every predicted command has left,
    // then give items without a result time to clear the pipeline.
    task automatic drain_block();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_cmds.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write all three registers on consecutive falling edges, block idle.
    // Spare data bits above a narrow register carry noise.
    task automatic load_settings(input logic spin, input logic [15:0] fwd,
                                 input logic [1:0] skew);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SPIN_FIRST;
        i_cfg_wdata <= {15'($urandom), spin};
        cfg_spin    = spin;
        @(negedge i_clk);
        i_cfg_index <= CFG_FORWARD_TICKS;
        i_cfg_wdata <= fwd;
        cfg_fwd     = fwd;
        @(negedge i_clk);
        i_cfg_index <= CFG_SKEW_MODE;
        i_cfg_wdata <= {14'($urandom), skew};
        cfg_skew    = skew;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly tick bursts and well-formed marker and obstacle episodes, so
    // the pattern gets through its turns; the rest is broken clears and noise.
    task automatic add_random(input int count);
        int         goal;
        int         pick;
        int         len;
        int         k;
        logic [7:0] value;
        goal = queued + count;
        while (queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                len = $urandom_range(1, 16);
                repeat (len) push_item(KIND_TICK, 8'($urandom));
            end else if (pick < 78) begin
                // marker seen for a few ticks, then lost again
                push_item(KIND_MARKER, 8'd1);
                len = $urandom_range(1, 6);
                repeat (len) push_item(KIND_TICK, 8'($urandom));
                value = 8'($urandom);
                if (value == 8'd1) value = 8'd0;
                push_item(KIND_MARKER, value);
            end else if (pick < 90) begin
                // obstacle, a pause, then six clear reports mixed with ticks
                value = 8'($urandom);
                if (value == 8'd0) value = 8'h80;
                push_item(KIND_OBSTACLE, value);
                len = $urandom_range(0, 5);
                repeat (len) push_item(KIND_TICK, 8'($urandom));
                for (k = 0; k < 6; k++) begin
                    push_item(KIND_OBSTACLE, 8'd0);
                    if ($urandom_range(0, 2) == 0) push_item(KIND_TICK, 8'($urandom));
                end
            end else if (pick < 95) begin
                // clear run cut short: the obstacle stays up
                value = 8'($urandom);
                if (value == 8'd0) value = 8'h01;
                push_item(KIND_OBSTACLE, value);
                len = $urandom_range(1, 5);
                repeat (len) push_item(KIND_OBSTACLE, 8'd0);
                push_item(KIND_TICK, 8'($urandom));
            end else begin
                push_item(2'($urandom), 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 31;
        recv_idle_pct = 74;

        // Directed, on reset settings: unused kind, marker set and released by
        // a non-one value, an obstacle that pauses and is cleared by six zero
        // reports, a nonzero report restarting the clear run, a zero report
        // while already clear, and the resume with forward timing restarted.
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_UNUSED, 8'h7F);
        push_item(KIND_TICK, 8'h55);
        push_item(KIND_MARKER, 8'd1);
        push_item(KIND_TICK, 8'hAA);
        push_item(KIND_TICK, 8'h01);
        push_item(KIND_MARKER, 8'h80);
        push_item(KIND_TICK, 8'h80);
        push_item(KIND_OBSTACLE, 8'h7F);
        push_item(KIND_TICK, 8'h7F);
        push_item(KIND_TICK, 8'h00);
        repeat (3) push_item(KIND_OBSTACLE, 8'd0);
        push_item(KIND_OBSTACLE, 8'hFF);
        repeat (6) push_item(KIND_OBSTACLE, 8'd0);
        push_item(KIND_OBSTACLE, 8'd0);
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_TICK, 8'h00);
        drain_block();

        // spin first, short legs, right skew
        load_settings(1'b1, 16'd5, SKEW_RIGHT);
        add_random(150);
        drain_block();

        // sender idles heavily, receiver lightly; zero-length legs, left skew
        send_idle_pct = 74;
        recv_idle_pct = 31;
        load_settings(1'b0, 16'd0, SKEW_LEFT);
        add_random(150);
        drain_block();

        // No idling. Release marker and obstacle, then a random mix with the
        // odd skew code meaning no skew.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(1'b0, 16'd0, SKEW_ODD);
        push_item(KIND_MARKER, 8'd0);
        repeat (6) push_item(KIND_OBSTACLE, 8'd0);
        add_random(150);
        drain_block();

        // longest forward leg, spin requested again, no skew
        load_settings(1'b1, 16'hFFFF, SKEW_NONE);
        add_random(80);
        drain_block();

        $display("Summary: %0d ticks, %0d marker, %0d obstacle, %0d unused-kind transactions;",
                 n_tick, n_marker, n_obstacle, n_unused);
        $display("Summary: %0d commands checked over spin on/off, legs 0 to 65535, %s %0d",
                 cmds_checked, "all four skew codes; peak cycle count", peak_legs);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
